>>> rtl/core/aces_tonemap_gamma_pixel_macros.svh
// Assertion macros shared by the tone-mapping pixel block.
`ifndef ACES_TONEMAP_GAMMA_PIXEL_MACROS_SVH
`define ACES_TONEMAP_GAMMA_PIXEL_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside of reset.
`define ATGP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("atgp assertion failed");
// Check a property on every clock edge, reset included.
`define ATGP_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("atgp assertion failed");
`else
`define ATGP_ASSERT(lbl, prop)
`define ATGP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/core/atgp_pkg.sv
`timescale 1ns / 1ps
package atgp_pkg;

   // One result pixel as three gamma-encoded bytes.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   localparam int IN_W       = 24;
   localparam int Q_W        = 16;
   localparam int NUM_W      = 57;
   localparam int DEN_W      = 58;
   localparam int LANE_LAT   = 20;
   localparam int FIFO_DEPTH = 32;
   localparam int PTR_W      = 5;
   localparam int CNT_W      = 6;

   typedef logic [255:0] big_type;

   // Exact integer power for the gamma table search.
   function automatic big_type big_pow(input big_type v, input int e);
      big_type p;
      p = 256'd1;
      for (int n = 0; n < e; n++) begin
         p = p * v;
      end
      return p;
   endfunction

   // Largest byte b with (100*b)^11 * 2^(5*g) <= 25599^11 * i^5.
   function automatic logic [7:0] gamma_entry(input int i, input int g);
      big_type rhs;
      big_type lhs;
      logic [7:0] lo;
      logic [7:0] cand;
      rhs = big_pow(256'd25599, 11) * big_pow(big_type'(i), 5);
      lo  = 8'd0;
      for (int s = 7; s >= 0; s--) begin
         cand = lo | (8'd1 << s);
         lhs  = big_pow(big_type'(100 * int'(cand)), 11) << (5 * g);
         if (lhs <= rhs) begin
            lo = cand;
         end
      end
      return lo;
   endfunction

endpackage

>>> rtl/core/atgp_lane.sv
`timescale 1ns / 1ps
module atgp_lane #(
   parameter int INPUT_FRAC_BITS  = 16,
   parameter int GAMMA_TABLE_BITS = 12
) (
   input  logic                      clock,
   input  logic [atgp_pkg::IN_W-1:0] lane_x,
   output logic [7:0]                lane_byte
);
   import atgp_pkg::*;

   localparam int TableSize = 1 << GAMMA_TABLE_BITS;
   localparam logic [31:0]      ThreeS     = 32'(3) << INPUT_FRAC_BITS;
   localparam logic [32:0]      FiftyNineS = 33'(59) << INPUT_FRAC_BITS;
   localparam logic [DEN_W-1:0] FourteenSS = DEN_W'(14) << (2 * INPUT_FRAC_BITS);

   logic [IN_W-1:0]  x_ff;
   logic [IN_W-1:0]  x2_ff;
   logic [31:0]      a_ff;
   logic [32:0]      c_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] dq_ff  [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic             sat_ff [Q_W];
   logic [Q_W-1:0]   t_val;
   logic [GAMMA_TABLE_BITS-1:0] idx;
   logic [7:0]       rom [TableSize];
   logic [7:0]       byte_ff;

   // Linear terms of numerator and denominator polynomials.
   always_ff @(posedge clock) begin
      x_ff  <= lane_x;
      x2_ff <= x_ff;
      a_ff  <= 32'(x_ff) * 32'd251 + ThreeS;
      c_ff  <= 33'(x_ff) * 33'd243 + FiftyNineS;
   end

   // One multiplier each for numerator and denominator.
   always_ff @(posedge clock) begin
      num_ff <= NUM_W'(x2_ff) * NUM_W'(a_ff);
      den_ff <= DEN_W'(x2_ff) * DEN_W'(c_ff) + FourteenSS;
   end

   // Restoring division, one quotient bit per stage.
   for (genvar k = 0; k < Q_W; k++) begin : g_div
      logic [DEN_W-1:0] rem_i;
      logic [DEN_W-1:0] den_i;
      logic [Q_W-1:0]   q_i;
      logic             sat_i;
      logic [DEN_W:0]   sh;
      logic             ge;
      if (k == 0) begin : g_first
         assign rem_i = DEN_W'(num_ff);
         assign den_i = den_ff;
         assign q_i   = '0;
         assign sat_i = DEN_W'(num_ff) >= den_ff;
      end else begin : g_next
         assign rem_i = rem_ff[k-1];
         assign den_i = dq_ff[k-1];
         assign q_i   = q_ff[k-1];
         assign sat_i = sat_ff[k-1];
      end
      assign sh = {rem_i, 1'b0};
      assign ge = sh >= {1'b0, den_i};
      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? DEN_W'(sh - {1'b0, den_i}) : sh[DEN_W-1:0];
         dq_ff[k]  <= den_i;
         q_ff[k]   <= {q_i[Q_W-2:0], ge};
         sat_ff[k] <= sat_i;
      end
   end

   // Constant gamma table, filled at elaboration.
   for (genvar i = 0; i < TableSize; i++) begin : g_rom
      localparam logic [7:0] Entry = gamma_entry(i, GAMMA_TABLE_BITS);
      assign rom[i] = Entry;
   end

   // Clamp at one, then look up the gamma-encoded byte.
   assign t_val = sat_ff[Q_W-1] ? {Q_W{1'b1}} : q_ff[Q_W-1];
   assign idx   = t_val[Q_W-1 -: GAMMA_TABLE_BITS];

   always_ff @(posedge clock) begin
      byte_ff <= rom[idx];
   end

   assign lane_byte = byte_ff;
endmodule

>>> rtl/core/atgp_merge.sv
`timescale 1ns / 1ps
module atgp_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  atgp_pkg::pixel_type push_pixel,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output atgp_pkg::pixel_type rsp_pixel
);
   import atgp_pkg::*;

   pixel_type        mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff;
   logic [PTR_W-1:0] wr_in;
   logic [PTR_W-1:0] rd_ff;
   logic [PTR_W-1:0] rd_in;
   logic [CNT_W-1:0] occ_ff;
   logic [CNT_W-1:0] occ_in;
   logic             pop;

   // Write each pushed pixel into the queue memory.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_pixel;
      end
   end

   // Pointer and occupancy update.
   always_comb begin
      pop    = rsp_valid && rsp_ready;
      wr_in  = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in  = pop ? rd_ff + PTR_W'(1) : rd_ff;
      occ_in = occ_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         occ_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         occ_ff <= occ_in;
      end
   end

   assign rsp_valid = occ_ff != '0;
   assign rsp_pixel = mem[rd_ff];
endmodule

>>> rtl/core/aces_tonemap_gamma_pixel.sv
`timescale 1ns / 1ps
// Pixels pass three channel lanes with pipelined dividers, then the result queue.
// Throughput: one pixel per cycle while a queue credit is free (req_ready high).
// A 32-entry result queue with credit counting lets input run while output stalls.
// Reset (synchronous, active high) empties the pipeline and the result queue.
module aces_tonemap_gamma_pixel #(
   parameter int INPUT_FRAC_BITS  = 16,
   parameter int GAMMA_TABLE_BITS = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [atgp_pkg::IN_W-1:0] req_hdr_red,
   input  logic [atgp_pkg::IN_W-1:0] req_hdr_green,
   input  logic [atgp_pkg::IN_W-1:0] req_hdr_blue,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_red,
   output logic [7:0]                rsp_out_green,
   output logic [7:0]                rsp_out_blue
);
   import atgp_pkg::*;

`include "aces_tonemap_gamma_pixel_macros.svh"

   logic [IN_W-1:0]     chan_x    [3];
   logic [7:0]          chan_byte [3];
   logic [LANE_LAT-1:0] vld_ff;
   logic [LANE_LAT-1:0] vld_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   logic                accept;
   logic                pop;
   pixel_type           push_pixel;
   pixel_type           rsp_pixel;

   assign chan_x[0] = req_hdr_red;
   assign chan_x[1] = req_hdr_green;
   assign chan_x[2] = req_hdr_blue;

   // One tone-mapping lane per color channel.
   for (genvar c = 0; c < 3; c++) begin : g_lane
      atgp_lane #(
         .INPUT_FRAC_BITS  (INPUT_FRAC_BITS),
         .GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
      ) u_lane (
         .clock     (clock),
         .lane_x    (chan_x[c]),
         .lane_byte (chan_byte[c])
      );
   end

   // Valid bits follow the lanes, and credits bound the items in flight.
   always_comb begin
      accept = req_valid && req_ready;
      pop    = rsp_valid && rsp_ready;
      vld_in = {vld_ff[LANE_LAT-2:0], accept};
      cnt_in = cnt_ff + CNT_W'(accept) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         cnt_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
   end

   assign req_ready = cnt_ff < CNT_W'(FIFO_DEPTH);

   assign push_pixel.red   = chan_byte[0];
   assign push_pixel.green = chan_byte[1];
   assign push_pixel.blue  = chan_byte[2];

   // Merge the lane results into the output queue.
   atgp_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (vld_ff[LANE_LAT-1]),
      .push_pixel (push_pixel),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pixel  (rsp_pixel)
   );

   assign rsp_out_red   = rsp_pixel.red;
   assign rsp_out_green = rsp_pixel.green;
   assign rsp_out_blue  = rsp_pixel.blue;

   // Reset always leaves no credits in use.
   `ATGP_ASSERT_ALWAYS(a_reset_clear, reset |=> cnt_ff == '0)
   // Credits never exceed the queue depth.
   `ATGP_ASSERT(a_cnt_bound, cnt_ff <= CNT_W'(FIFO_DEPTH))
   // A transfer in without one out raises the credit count by one.
   `ATGP_ASSERT(a_cnt_inc, accept && !pop |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
   // A waiting result always holds a credit.
   `ATGP_ASSERT(a_rsp_credit, rsp_valid |-> cnt_ff != '0)
endmodule

>>> test/tb_aces_tonemap_gamma_pixel.sv
`timescale 1ns / 1ps
module tb_aces_tonemap_gamma_pixel;
   import atgp_pkg::*;

   localparam int FRAC_BITS   = 16;
   localparam int TABLE_BITS  = 12;
   localparam int TABLE_SIZE  = 1 << TABLE_BITS;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 40;

   typedef struct packed {
      logic [23:0] red;
      logic [23:0] green;
      logic [23:0] blue;
   } hdr_pixel_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [23:0] req_hdr_red = '0;
   logic [23:0] req_hdr_green = '0;
   logic [23:0] req_hdr_blue = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_red;
   logic [7:0]  rsp_out_green;
   logic [7:0]  rsp_out_blue;

   hdr_pixel_type pending_pixels[$];
   pixel_type   expected_bytes[$];
   logic [7:0]  gamma_lut[TABLE_SIZE];
   int          mismatch_count = 0;
   int          result_count = 0;
   int          sent_count = 0;
   int          idle_cycles = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   bit          stim_done = 0;

   aces_tonemap_gamma_pixel dut (.*);

   always #10 clock = ~clock;

   // Exact integer gamma search: largest b with (100b)^11 * 2^(5g) <= 25599^11 * i^5.
   function automatic logic [7:0] gamma_byte(input int idx);
      logic [255:0] rhs;
      logic [255:0] lhs;
      logic [255:0] base;
      int b;
      rhs = 256'd1;
      for (int n = 0; n < 11; n++) rhs = rhs * 256'd25599;
      for (int n = 0; n < 5; n++) rhs = rhs * 256'(idx);
      b = 0;
      while (b < 255) begin
         base = 256'(100 * (b + 1));
         lhs = 256'd1;
         for (int n = 0; n < 11; n++) lhs = lhs * base;
         lhs = lhs << (5 * TABLE_BITS);
         if (lhs <= rhs) b++;
         else break;
      end
      return 8'(b);
   endfunction

   // Rational ACES fit in Q0.16 with saturation, then the gamma lookup.
   function automatic logic [7:0] tonemap_channel(input logic [23:0] v);
      logic [63:0] x;
      logic [63:0] one;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] rem;
      logic [15:0] q;
      x   = 64'(v);
      one = 64'd1 << FRAC_BITS;
      num = x * (64'd251 * x + 64'd3 * one);
      den = x * (64'd243 * x + 64'd59 * one) + 64'd14 * one * one;
      if (num >= den) begin
         q = 16'hFFFF;
      end else begin
         rem = num;
         q = '0;
         for (int k = 0; k < 16; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
               rem = rem - den;
               q[0] = 1'b1;
            end
         end
      end
      return gamma_lut[q >> (16 - TABLE_BITS)];
   endfunction

   function automatic logic [23:0] random_channel();
      case ($urandom_range(0, 5))
         0: return 24'($urandom);
         1: return 24'($urandom_range(0, 255));
         2: return 24'($urandom_range(0, 65535));
         3: return 24'($urandom_range(65536, 262143));
         4: return 24'hFFFFFF - 24'($urandom_range(0, 4095));
         default: return 24'($urandom_range(0, 1 << 20));
      endcase
   endfunction

   task automatic queue_pixel(input logic [23:0] r, input logic [23:0] g,
                              input logic [23:0] b);
      hdr_pixel_type p;
      p.red = r;
      p.green = g;
      p.blue = b;
      pending_pixels = {pending_pixels, p};
   endtask

   // Driver: present one pending pixel at a time, with a random gap before each.
   always @(posedge clock) begin
      hdr_pixel_type p;
      int gap;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sent_count <= sent_count + 1;
            gap = $urandom_range(0, 6);
            if (pending_pixels.size() > 0 && gap == 0) begin
               p = pending_pixels.pop_front();
               req_hdr_red <= p.red;
               req_hdr_green <= p.green;
               req_hdr_blue <= p.blue;
               expected_bytes = {expected_bytes, pixel_type'({tonemap_channel(p.red),
                  tonemap_channel(p.green), tonemap_channel(p.blue)})};
               req_valid <= 1'b1;
            end else begin
               send_gap <= (gap > 0) ? gap - 1 : 0;
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (pending_pixels.size() > 0) begin
               p = pending_pixels.pop_front();
               req_hdr_red <= p.red;
               req_hdr_green <= p.green;
               req_hdr_blue <= p.blue;
               expected_bytes = {expected_bytes, pixel_type'({tonemap_channel(p.red),
                  tonemap_channel(p.green), tonemap_channel(p.blue)})};
               req_valid <= 1'b1;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest expected pixel.
   always @(posedge clock) begin
      pixel_type want;
      pixel_type got;
      int gap;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_red, rsp_out_green, rsp_out_blue};
            result_count <= result_count + 1;
            if (expected_bytes.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("Unexpected result %h %h %h", got.red, got.green, got.blue);
            end else begin
               want = expected_bytes.pop_front();
               if (got !== want) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("Mismatch: expected %h %h %h, got %h %h %h",
                        want.red, want.green, want.blue, got.red, got.green, got.blue);
               end
            end
            gap = $urandom_range(0, 6);
            recv_gap <= (gap > 0) ? gap - 1 : 0;
            rsp_ready <= (gap == 0);
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no transfer at all.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired with %0d results pending", expected_bytes.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int wait_cycles;
      for (int i = 0; i < TABLE_SIZE; i++) gamma_lut[i] = gamma_byte(i);

      // Directed pixels: zero, smallest steps, one, saturation, and the top code.
      queue_pixel(24'h000000, 24'h000000, 24'h000000);
      queue_pixel(24'h000001, 24'h000002, 24'h000010);
      queue_pixel(24'h010000, 24'h008000, 24'h004000);
      queue_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      queue_pixel(24'hFFFFFF, 24'h000000, 24'h555555);
      queue_pixel(24'h000000, 24'hFFFFFF, 24'hAAAAAA);
      queue_pixel(24'h0A0000, 24'h020000, 24'h000100);
      queue_pixel(24'h800000, 24'h7FFFFF, 24'h00FFFF);
      queue_pixel(24'h001000, 24'h000800, 24'h000400);
      queue_pixel(24'h030000, 24'h0000FF, 24'hFF0000);
      for (int i = 0; i < 1100; i++)
         queue_pixel(random_channel(), random_channel(), random_channel());

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      wait (pending_pixels.size() == 0 && !req_valid);
      wait (expected_bytes.size() == 0);
      stim_done = 1;
      wait_cycles = 0;
      while (wait_cycles < DRAIN_WAIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      $display("Checked %0d pixels of %0d sent, covering zero, saturation and random",
         result_count, sent_count);
      $display("radiance across the full Q8.16 range under random stalls on both sides.");
      if (mismatch_count == 0 && expected_bytes.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
